// ===== rtl/top_k_level_difference_macros.svh =====
`ifndef TOP_K_LEVEL_DIFFERENCE_MACROS_SVH
`define TOP_K_LEVEL_DIFFERENCE_MACROS_SVH

// same-cycle implication, checked on clk with reset masked
`define TKLD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkld check failed: same-cycle implication");

// next-cycle implication, checked on clk with reset masked
`define TKLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkld check failed: next-cycle implication");

`endif

// ===== rtl/tkld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkld_pkg;

    localparam int MAX_TOP_COUNT_DEF = 16;
    localparam int LEVEL_BITS_DEF    = 24;
    localparam int FRAME_BITS        = 31;
    localparam int TOP_COUNT_BITS    = 5;
    localparam int APB_DATA_BITS     = 32;
    localparam int APB_ADDR_BITS     = 2;

    localparam logic [TOP_COUNT_BITS-1:0] TOP_COUNT_RESET = 5'd16;
    localparam logic [APB_ADDR_BITS-1:0]  ADDR_TOP_COUNT  = 2'd0;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    // per-cycle command broadcast along the cell chain
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    // effective table size: zero means one, saturate at the table depth
    function automatic int limit_of(input logic [TOP_COUNT_BITS-1:0] top, input int max_count);
        int result;
        if (top == '0)
            result = 1;
        else if (int'(top) > max_count)
            result = max_count;
        else
            result = int'(top);
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tkld_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkld_cell #(
    parameter int LEVEL_BITS = tkld_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire tkld_pkg::cell_ctrl_t  ctrl,
    input  wire logic                  enable,
    input  wire logic                  occupied,
    input  wire logic [tkld_pkg::FRAME_BITS+3*LEVEL_BITS-1:0] new_entry,
    input  wire logic                  left_gt,
    input  wire logic [tkld_pkg::FRAME_BITS+3*LEVEL_BITS-1:0] left_entry,
    input  wire logic [tkld_pkg::FRAME_BITS+3*LEVEL_BITS-1:0] right_entry,
    output logic                       gt,
    output logic [tkld_pkg::FRAME_BITS+3*LEVEL_BITS-1:0] entry
);

    localparam int ENTRY_BITS = tkld_pkg::FRAME_BITS + 3 * LEVEL_BITS;

    logic [ENTRY_BITS-1:0] entry_reg;
    logic [ENTRY_BITS-1:0] entry_next;
    logic [LEVEL_BITS-1:0] diff_cur;
    logic [LEVEL_BITS-1:0] diff_new;

    assign diff_cur = entry_reg[LEVEL_BITS-1:0];
    assign diff_new = new_entry[LEVEL_BITS-1:0];

    // new word belongs at or before this slot (strictly larger, ties stay behind)
    assign gt = enable && (!occupied || (diff_new > diff_cur));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.insert)
        begin
            if (left_gt)
                entry_next = left_entry;
            else if (gt)
                entry_next = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/top_k_level_difference.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       frame_index, in_level, out_level, end_of_data
// result    output     result_valid / result_ready  result_frame, result_difference,
//                                                 result_in_level, result_out_level, result_last
// apb       input      psel / penable / pready   paddr, pwdata, prdata (top_count at 0x0)
//
// one record is taken per cycle while collecting; the sorted cell chain inserts it in that cycle
// an end_of_data word starts a drain of the kept words (0..MAX_TOP_COUNT), one word a cycle,
// paced by the chain shifting toward cell 0; no input is taken during the drain
// a held result word pauses the drain and so the input; a held last word blocks nothing
// rst_n clears the kept count, the drain state and the output valid; no clearing pass is needed

module top_k_level_difference #(
    parameter int MAX_TOP_COUNT = tkld_pkg::MAX_TOP_COUNT_DEF,
    parameter int LEVEL_BITS    = tkld_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // record input
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [tkld_pkg::FRAME_BITS-1:0]       frame_index,
    input  wire logic [LEVEL_BITS-1:0]                 in_level,
    input  wire logic [LEVEL_BITS-1:0]                 out_level,
    input  wire logic                                  end_of_data,
    // result output
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic [tkld_pkg::FRAME_BITS-1:0]            result_frame,
    output logic [LEVEL_BITS-1:0]                      result_difference,
    output logic [LEVEL_BITS-1:0]                      result_in_level,
    output logic [LEVEL_BITS-1:0]                      result_out_level,
    output logic                                       result_last,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tkld_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [tkld_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [tkld_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                       pready
);

    localparam int ENTRY_BITS = tkld_pkg::FRAME_BITS + 3 * LEVEL_BITS;
    localparam int CNT_BITS   = $clog2(MAX_TOP_COUNT + 1);
    localparam int TC_BITS    = tkld_pkg::TOP_COUNT_BITS;

    // entry layout: {frame, in level, out level, difference}
    localparam int DIFF_LO  = 0;
    localparam int OUTL_LO  = LEVEL_BITS;
    localparam int INL_LO   = 2 * LEVEL_BITS;
    localparam int FRAME_LO = 3 * LEVEL_BITS;

    tkld_pkg::state_t state_reg;
    tkld_pkg::state_t state_next;

    logic [TC_BITS-1:0]  top_count_reg;
    logic [TC_BITS-1:0]  top_count_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic [CNT_BITS-1:0] limit;
    logic [CNT_BITS-1:0] limit_cfg;

    logic                            result_valid_reg;
    logic                            result_valid_next;
    logic                            result_last_reg;
    logic [tkld_pkg::FRAME_BITS-1:0] result_frame_reg;
    logic [LEVEL_BITS-1:0]           result_diff_reg;
    logic [LEVEL_BITS-1:0]           result_in_reg;
    logic [LEVEL_BITS-1:0]           result_out_reg;

    logic                       in_fire;
    logic                       pop;
    logic                       cfg_write;
    logic                       any_gt;
    logic [LEVEL_BITS-1:0]      abs_diff;
    logic [ENTRY_BITS-1:0]      new_entry;
    tkld_pkg::cell_ctrl_t       ctrl;

    logic [MAX_TOP_COUNT-1:0]   gt_vec;
    logic [ENTRY_BITS-1:0]      ent [MAX_TOP_COUNT];

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == tkld_pkg::ADDR_TOP_COUNT);
    assign limit     = CNT_BITS'(tkld_pkg::limit_of(top_count_reg, MAX_TOP_COUNT));
    assign limit_cfg = CNT_BITS'(tkld_pkg::limit_of(pwdata[TC_BITS-1:0], MAX_TOP_COUNT));

    always_comb
    begin
        prdata = '0;
        if (paddr == tkld_pkg::ADDR_TOP_COUNT)
            prdata = {{(tkld_pkg::APB_DATA_BITS - TC_BITS){1'b0}}, top_count_reg};
    end

    assign top_count_next = cfg_write ? pwdata[TC_BITS-1:0] : top_count_reg;

    // ------------------------------------------------------------------
    // incoming record
    // ------------------------------------------------------------------
    assign abs_diff  = (out_level >= in_level) ? (out_level - in_level) : (in_level - out_level);
    assign new_entry = {frame_index, in_level, out_level, abs_diff};

    // ------------------------------------------------------------------
    // control: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkld_pkg::ST_COLLECT:
            begin
                if (in_fire && end_of_data)
                    state_next = tkld_pkg::ST_DRAIN;
            end
            tkld_pkg::ST_DRAIN:
            begin
                // last kept word leaves, or nothing was kept at all
                if ((pop && count_reg == CNT_BITS'(1)) || count_reg == '0)
                    state_next = tkld_pkg::ST_COLLECT;
            end
            default:
            begin
                state_next = tkld_pkg::ST_COLLECT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        pop      = 1'b0;
        unique case (state_reg)
            tkld_pkg::ST_COLLECT:
            begin
                in_ready = 1'b1;
            end
            tkld_pkg::ST_DRAIN:
            begin
                // move head of chain into the output register when it is free
                pop = (count_reg != '0) && (!result_valid_reg || result_ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire     = in_valid && in_ready;
    assign ctrl.insert = in_fire;
    assign ctrl.pop    = pop;
    assign any_gt      = |gt_vec;

    // kept count: grows on an insert until full, shrinks per drained word,
    // clamps at once when the limit is lowered
    always_comb
    begin
        count_next = count_reg;
        if (cfg_write)
        begin
            if (count_reg > limit_cfg)
                count_next = limit_cfg;
        end
        else if (pop)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
        else if (in_fire && any_gt && (count_reg < limit))
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    // ------------------------------------------------------------------
    // sorted cell chain, cell 0 holds the largest difference
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_TOP_COUNT; i++)
    begin : g_cell
        localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(i);

        logic                  left_gt;
        logic [ENTRY_BITS-1:0] left_entry;
        logic [ENTRY_BITS-1:0] right_entry;

        if (i == 0)
        begin : g_head
            assign left_gt    = 1'b0;
            assign left_entry = new_entry;
        end
        else
        begin : g_body
            assign left_gt    = gt_vec[i-1];
            assign left_entry = ent[i-1];
        end

        if (i == MAX_TOP_COUNT - 1)
        begin : g_tail
            assign right_entry = ent[i];
        end
        else
        begin : g_mid
            assign right_entry = ent[i+1];
        end

        tkld_cell #(
            .LEVEL_BITS (LEVEL_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .enable      (IDX < limit),
            .occupied    (IDX < count_reg),
            .new_entry   (new_entry),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .gt          (gt_vec[i]),
            .entry       (ent[i])
        );
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (pop)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_frame_reg <= ent[0][FRAME_LO +: tkld_pkg::FRAME_BITS];
            result_in_reg    <= ent[0][INL_LO +: LEVEL_BITS];
            result_out_reg   <= ent[0][OUTL_LO +: LEVEL_BITS];
            result_diff_reg  <= ent[0][DIFF_LO +: LEVEL_BITS];
            result_last_reg  <= (count_reg == CNT_BITS'(1));
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tkld_pkg::ST_COLLECT;
            top_count_reg    <= tkld_pkg::TOP_COUNT_RESET;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            top_count_reg    <= top_count_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid      = result_valid_reg;
    assign result_frame      = result_frame_reg;
    assign result_difference = result_diff_reg;
    assign result_in_level   = result_in_reg;
    assign result_out_level  = result_out_reg;
    assign result_last       = result_last_reg;

endmodule

`default_nettype wire

// ===== rtl/tkld_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "top_k_level_difference_macros.svh"

module tkld_checker #(
    parameter int LEVEL_BITS = tkld_pkg::LEVEL_BITS_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_ready,
    input wire logic                            result_valid,
    input wire logic                            result_ready,
    input wire logic [tkld_pkg::FRAME_BITS-1:0] result_frame,
    input wire logic [LEVEL_BITS-1:0]           result_difference,
    input wire logic [LEVEL_BITS-1:0]           result_in_level,
    input wire logic [LEVEL_BITS-1:0]           result_out_level,
    input wire logic                            result_last
);

    // a stalled result word holds
    `TKLD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_frame) && $stable(result_difference))

    // reported difference matches the reported levels
    `TKLD_ASSERT_NOW(a_diff_consistent, result_valid, result_difference == ((result_in_level >= result_out_level) ? (result_in_level - result_out_level) : (result_out_level - result_in_level)))

    // mid-report no new record is taken
    `TKLD_ASSERT_NOW(a_no_input_mid_report, result_valid && !result_last, !in_ready)

    // report runs back to back in non-increasing order of difference
    `TKLD_ASSERT_NEXT(a_descending, result_valid && result_ready && !result_last, result_valid && (result_difference <= $past(result_difference)))

endmodule

bind top_k_level_difference tkld_checker #(
    .LEVEL_BITS (LEVEL_BITS)
) u_tkld_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ready),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .result_frame      (result_frame),
    .result_difference (result_difference),
    .result_in_level   (result_in_level),
    .result_out_level  (result_out_level),
    .result_last       (result_last)
);

`default_nettype wire
